### design/bsq_pkg.sv
// Shared types and constants for the binary semaphore with blocking wait queues.
// Used by bsq_front, bsq_back and binary_semaphore_wait_queues_core; no dependencies.
package bsq_pkg;

  // Depth of each wait queue (ids held per queue)
  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Command queue between front and back
  localparam int unsigned CMD_DEPTH  = 2;
  localparam int unsigned CMD_PTR_W  = $clog2(CMD_DEPTH);
  localparam int unsigned CMD_CNT_W  = $clog2(CMD_DEPTH + 1);

  localparam int unsigned ID_W = 8;

  typedef enum logic {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_PROCEED = 2'd0,
    ST_BLOCKED = 2'd1,
    ST_WOKE    = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef struct packed {
    op_e             op;
    logic [ID_W-1:0] id;
  } cmd_t;

  typedef struct packed {
    status_e         status;
    logic [ID_W-1:0] woken_id;
  } res_t;

  // Observation of the back end's semaphore state
  typedef struct packed {
    logic              sem_free;
    logic [QCNT_W-1:0] acq_cnt;
    logic [QCNT_W-1:0] rel_cnt;
  } sem_stat_t;

endpackage

### design/bsq_front.sv
// Front end: accepts request words, decodes the op and holds them in a short
// command queue for the back end. Depends on bsq_pkg.
module bsq_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  in_op_i,
  input  logic [bsq_pkg::ID_W-1:0] in_id_i,
  output logic                  cmd_valid_o,
  input  logic                  cmd_ready_i,
  output bsq_pkg::cmd_t         cmd_o
);
  import bsq_pkg::*;

  cmd_t                 slot_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMD_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMD_CNT_W-1:0] cnt_q, cnt_d;
  logic                 push, pop;
  cmd_t                 cmd_in;

  assign in_ready_o  = (cnt_q != CMD_CNT_W'(CMD_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = slot_q[rd_ptr_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = cmd_valid_o && cmd_ready_i;

  always_comb begin
    cmd_in.op = op_e'(in_op_i);
    cmd_in.id = in_id_i;
  end

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

### design/bsq_back.sv
// Back end: semaphore flag, the acquire and release wait queues, and the
// result register. Depends on bsq_pkg.
module bsq_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  bsq_pkg::cmd_t      cmd_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output bsq_pkg::res_t      res_o,
  output bsq_pkg::sem_stat_t stat_o
);
  import bsq_pkg::*;

  localparam logic QACQ = 1'b0;
  localparam logic QREL = 1'b1;

  // Index 0 holds blocked acquirers, index 1 blocked releasers
  logic [ID_W-1:0]   slot_q [2][QUEUE_DEPTH];
  logic [QPTR_W-1:0] head_q [2];
  logic [QPTR_W-1:0] head_d [2];
  logic [QPTR_W-1:0] tail_q [2];
  logic [QPTR_W-1:0] tail_d [2];
  logic [QCNT_W-1:0] cnt_q  [2];
  logic [QCNT_W-1:0] cnt_d  [2];
  logic              sem_free_q, sem_free_d;
  logic              out_valid_q, out_valid_d;
  res_t              res_q, res_d;

  logic fire, own, other, blocks, own_full, wr_en, rd_en;

  function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
    ptr_next = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign cmd_ready_o = !out_valid_q || res_ready_i;
  assign fire        = cmd_valid_i && cmd_ready_o;
  assign own         = (cmd_i.op == OP_RELEASE) ? QREL : QACQ;
  assign other       = ~own;
  assign blocks      = (cmd_i.op == OP_RELEASE) ? sem_free_q : !sem_free_q;
  assign own_full    = (cnt_q[own] == QCNT_W'(QUEUE_DEPTH));

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    cnt_d       = cnt_q;
    sem_free_d  = sem_free_q;
    res_d       = res_q;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    out_valid_d = out_valid_q && !res_ready_i;
    if (fire) begin
      out_valid_d    = 1'b1;
      res_d.woken_id = '0;
      priority if (blocks && own_full) begin
        res_d.status = ST_FULL;
      end else if (blocks) begin
        wr_en        = 1'b1;
        tail_d[own]  = ptr_next(tail_q[own]);
        cnt_d[own]   = cnt_q[own] + 1'b1;
        res_d.status = ST_BLOCKED;
      end else if (cnt_q[other] != '0) begin
        rd_en          = 1'b1;
        head_d[other]  = ptr_next(head_q[other]);
        cnt_d[other]   = cnt_q[other] - 1'b1;
        res_d.status   = ST_WOKE;
      end else begin
        sem_free_d   = (cmd_i.op == OP_RELEASE);
        res_d.status = ST_PROCEED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sem_free_q  <= 1'b1;
      out_valid_q <= 1'b0;
      for (int q = 0; q < 2; q++) begin
        head_q[q] <= '0;
        tail_q[q] <= '0;
        cnt_q[q]  <= '0;
      end
    end else begin
      sem_free_q  <= sem_free_d;
      out_valid_q <= out_valid_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
    end
  end

  // Read the head waiter straight into the result register on a wake
  always_ff @(posedge clk_i) begin
    res_q.status   <= res_d.status;
    res_q.woken_id <= rd_en ? slot_q[other][head_q[other]] : res_d.woken_id;
    if (wr_en) begin
      slot_q[own][tail_q[own]] <= cmd_i.id;
    end
  end

  assign res_valid_o     = out_valid_q;
  assign res_o           = res_q;
  assign stat_o.sem_free = sem_free_q;
  assign stat_o.acq_cnt  = cnt_q[QACQ];
  assign stat_o.rel_cnt  = cnt_q[QREL];

endmodule

### design/binary_semaphore_wait_queues_core.sv
// Top level of the binary semaphore with blocking P and V wait queues.
// Instantiates bsq_front and bsq_back; depends on bsq_pkg.
//
//  channel   dir  tdata            tuser
//  s_axis    in   requester_id     op (0 acquire, 1 release)
//  m_axis    out  woken_id         status
//
// One request per cycle sustained while m_axis_tready stays high; each word gives
// one result, held first in the command queue register, then in the result register.
// The back end updates either the flag or one wait queue head or tail per cycle.
// Reset frees the semaphore and empties both wait queues; no clearing pass.
// A stalled m_axis holds its result while the two-entry command queue fills,
// then s_axis_tready drops.
module binary_semaphore_wait_queues_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [7:0]               s_axis_tdata,  // [7:0] requester_id
  input  logic [0:0]               s_axis_tuser,  // [0] op
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [7:0]               m_axis_tdata,  // [7:0] woken_id
  output logic [1:0]               m_axis_tuser   // [1:0] status
);
  import bsq_pkg::*;

  logic      cmd_valid, cmd_ready;
  cmd_t      cmd;
  res_t      res;
  sem_stat_t stat;

  bsq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser[0]),
    .in_id_i     (s_axis_tdata),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  bsq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res),
    .stat_o      (stat)
  );

  assign m_axis_tdata = res.woken_id;
  assign m_axis_tuser = res.status;

`ifndef SYNTHESIS
  // Blocked acquirers exist only while the semaphore is taken
  a_acq_wait_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.acq_cnt != '0) |-> !stat.sem_free)
    else $error("acquire waiters while semaphore free");

  // Blocked releasers exist only while the semaphore is free
  a_rel_wait_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.rel_cnt != '0) |-> stat.sem_free)
    else $error("release waiters while semaphore taken");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.acq_cnt <= QCNT_W'(QUEUE_DEPTH)) && (stat.rel_cnt <= QCNT_W'(QUEUE_DEPTH)))
    else $error("wait queue count beyond depth");

  a_woken_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (res.status != ST_WOKE)) |-> (res.woken_id == '0))
    else $error("woken id set without a wake");
`endif

endmodule

### test/tb_binary_semaphore_wait_queues_core.sv
// Testbench for binary_semaphore_wait_queues_core: directed and random P/V requests,
// each result checked against a local semaphore predictor. Depends on bsq_pkg.
`timescale 1ns / 1ps

module tb_binary_semaphore_wait_queues_core;
  import bsq_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = '0;  // [7:0] requester_id
  logic [0:0] s_axis_tuser  = '0;  // [0] op
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;        // [7:0] woken_id
  logic [1:0] m_axis_tuser;        // [1:0] status

  // Semaphore predictor state
  logic            sem_is_free = 1'b1;
  logic [ID_W-1:0] acq_waiters[$];
  logic [ID_W-1:0] rel_waiters[$];
  res_t            pending_results[$];

  int   error_count   = 0;
  int   request_count = 0;
  int   status_seen[4] = '{default: 0};
  int   quiet_cycles  = 0;
  int   stall_left    = 0;
  logic idle_on       = 1'b1;

  binary_semaphore_wait_queues_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // P blocks on a taken flag, V on a free one; otherwise wake the opposite head
  // waiter if there is one, else flip the flag. A block on a full queue is rejected.
  function automatic res_t semaphore_outcome(input op_e op, input logic [ID_W-1:0] id);
    res_t r;
    logic blocks;
    r.status   = ST_PROCEED;
    r.woken_id = '0;
    blocks = (op == OP_RELEASE) ? sem_is_free : !sem_is_free;
    if (blocks) begin
      if (op == OP_RELEASE) begin
        if (rel_waiters.size() >= QUEUE_DEPTH) r.status = ST_FULL;
        else begin
          rel_waiters.push_back(id);
          r.status = ST_BLOCKED;
        end
      end else begin
        if (acq_waiters.size() >= QUEUE_DEPTH) r.status = ST_FULL;
        else begin
          acq_waiters.push_back(id);
          r.status = ST_BLOCKED;
        end
      end
    end else if (op == OP_ACQUIRE && rel_waiters.size() > 0) begin
      r.woken_id = rel_waiters.pop_front();
      r.status   = ST_WOKE;
    end else if (op == OP_RELEASE && acq_waiters.size() > 0) begin
      r.woken_id = acq_waiters.pop_front();
      r.status   = ST_WOKE;
    end else begin
      sem_is_free = (op == OP_RELEASE);
    end
    return r;
  endfunction

  // Check the outgoing word first, then predict the incoming one
  always @(posedge clk_i) begin
    res_t exp_res;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: status %0d woken_id %0d",
                 m_axis_tuser, m_axis_tdata);
          error_count++;
        end else begin
          exp_res = pending_results.pop_front();
          status_seen[m_axis_tuser]++;
          if (m_axis_tuser !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, m_axis_tuser);
            error_count++;
          end
          if (m_axis_tdata !== exp_res.woken_id) begin
            $error("woken_id: expected %0d, got %0d", exp_res.woken_id, m_axis_tdata);
            error_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pending_results.push_back(semaphore_outcome(op_e'(s_axis_tuser[0]), s_axis_tdata));
        request_count++;
      end
    end
  end

  // Receiver back-pressure in bursts
  always @(posedge clk_i) begin
    if (idle_on && stall_left == 0 && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 14);
    else if (stall_left > 0)
      stall_left--;
    m_axis_tready <= rst_ni && (stall_left == 0);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Present one word and hold it until accepted
  task automatic send_request(input op_e op, input logic [ID_W-1:0] id);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tvalid   <= 1'b1;
    s_axis_tdata    <= id;
    s_axis_tuser[0] <= op;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Step to the next clock edge first so the last accepted word is already predicted
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_request(OP_ACQUIRE, 8'h00);  // free: proceed, taken
    send_request(OP_RELEASE, 8'hFF);  // no acquire waiters: proceed, free
    send_request(OP_RELEASE, 8'hAA);  // free: release caller blocks
    send_request(OP_ACQUIRE, 8'h55);  // wakes the blocked releaser, stays free
    send_request(OP_ACQUIRE, 8'h01);  // take it
    for (int i = 0; i < QUEUE_DEPTH; i++)
      send_request(OP_ACQUIRE, 8'(255 - i * 15));
    send_request(OP_ACQUIRE, 8'h7E);  // acquire queue full: rejected
    send_request(OP_RELEASE, 8'h3C);  // wakes the head acquirer
    send_request(OP_RELEASE, 8'h00);
    wait_drained();
  endtask

  // Runs biased towards P or V drive the flag and both queues to their limits
  task automatic test_random_traffic(input int n_items, input logic with_idle);
    int done_items;
    int run_len;
    int release_pct;
    done_items = 0;
    while (done_items < n_items) begin
      run_len = $urandom_range(10, 60);
      case ($urandom_range(0, 3))
        0:       release_pct = 10;
        1:       release_pct = 90;
        default: release_pct = 50;
      endcase
      idle_on = with_idle && ($urandom_range(0, 3) != 0);
      for (int i = 0; i < run_len && done_items < n_items; i++) begin
        send_request(($urandom_range(0, 99) < release_pct) ? OP_RELEASE : OP_ACQUIRE,
                     8'($urandom_range(0, 255)));
        done_items++;
      end
    end
  endtask

  task automatic test_pause_until_drained();
    wait_drained();
    send_request(OP_ACQUIRE, 8'($urandom_range(0, 255)));
    send_request(OP_RELEASE, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_traffic(800, 1'b1);
    test_pause_until_drained();
    test_random_traffic(500, 1'b1);
    idle_on = 1'b0;
    test_random_traffic(200, 1'b0);

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("results: expected %0d more words, got none", pending_results.size());
      error_count++;
    end
    $display("Covered %0d requests: %0d proceeded, %0d blocked, %0d woke a waiter,",
             request_count, status_seen[ST_PROCEED], status_seen[ST_BLOCKED],
             status_seen[ST_WOKE]);
    $display("%0d rejected on a full wait queue.", status_seen[ST_FULL]);
    if (error_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
